>>> hdl/mmc1_pkg.sv
// shared types and constants for the mmc1 bank mapper
package mmc1_pkg;

  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 8;
  localparam int STAMP_W = 48;
  localparam int LAST_W  = STAMP_W + 1;

  typedef enum logic [1:0] {
    OP_CPU_WRITE = 2'd0,
    OP_CPU_READ  = 2'd1,
    OP_PPU_READ  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_PRG  = 2'd0,
    KIND_RAM  = 2'd1,
    KIND_CHR  = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  // loader destination, from address bits 14:13
  typedef enum logic [1:0] {
    TGT_CONTROL  = 2'd0,
    TGT_CHR_LOW  = 2'd1,
    TGT_CHR_HIGH = 2'd2,
    TGT_PRG      = 2'd3
  } load_target_t;

  localparam logic [4:0] LOAD_SHIFT_RESET   = 5'h10;
  localparam logic [4:0] CONTROL_RESET      = 5'h1F;
  localparam logic [4:0] CONTROL_LOADER_SET = 5'h0C;
  localparam logic [2:0] LOAD_LAST_COUNT    = 3'd4;
  localparam logic signed [LAST_W-1:0] LAST_STAMP_RESET = -49'sd100;

endpackage

>>> hdl/mmc1_ifs.sv
// request and response channel interfaces for the mmc1 bank mapper
interface mmc1_req_if;
  import mmc1_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          op;
  logic [ADDR_W-1:0]   bus_address;
  logic [DATA_W-1:0]   write_data;
  logic [STAMP_W-1:0]  cycle_stamp;

  modport source (output valid, op, bus_address, write_data, cycle_stamp, input ready);
  modport sink   (input valid, op, bus_address, write_data, cycle_stamp, output ready);
endinterface

interface mmc1_rsp_if;
  import mmc1_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        result_kind;
  logic [ADDR_W-1:0] rom_address;
  logic [DATA_W-1:0] read_data;
  logic [1:0]        mirroring;
  logic              write_taken;

  modport source (output valid, result_kind, rom_address, read_data, mirroring, write_taken,
                  input ready);
  modport sink   (input valid, result_kind, rom_address, read_data, mirroring, write_taken,
                  output ready);
endinterface

>>> hdl/mmc1_ram.sv
// generic single-port ram with registered read
module mmc1_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> hdl/mmc1_bank_mapper.sv
// mmc1 bank mapper top level: serial loader, bank registers and work ram
//
// usage:
//   req carries one bus access per transfer: op (cpu write, cpu read, ppu
//   pattern read), bus_address, write_data and cycle_stamp.
//   rsp returns exactly one result per request, in order: result_kind,
//   rom_address (mapped prg or chr rom address), read_data (work ram byte),
//   mirroring (control bits 1:0 after the access) and write_taken.
// timing:
//   one request per cycle sustained while rsp.ready is high; a result shows
//   on rsp once its request transfer has passed both stages. the work ram read
//   port (registered read) sets the first stage, the output register the second.
//   loader and bank registers update in the cycle of the request transfer,
//   so the next request already sees the new banking.
// reset (rst, synchronous): loader empty, control 0x1f, banks zero, both
//   stages empty. work ram contents are not cleared.
// stall: when rsp.ready is low the output register holds; one more request
//   is taken into the ram stage, then req.ready drops until rsp drains.
module mmc1_bank_mapper #(
  parameter int PRG_BANK_COUNT = 4,
  parameter int CHR_BANK_COUNT = 2,
  parameter int RAM_BYTES      = 8192
) (
  input  logic         clk,
  input  logic         rst,
  mmc1_req_if.sink     req,
  mmc1_rsp_if.source   rsp
);
  import mmc1_pkg::*;

  localparam int RAM_AW   = $clog2(RAM_BYTES);
  localparam int WIN_SIZE = 8192;  // 0x6000-0x7fff window

  // bank registers and loader
  logic [4:0]               load_shift, load_shift_next;
  logic [2:0]               load_count, load_count_next;
  logic [4:0]               control_reg, control_reg_next;
  logic [4:0]               prg_bank_reg, prg_bank_reg_next;
  logic [4:0]               chr_low_bank, chr_low_bank_next;
  logic [4:0]               chr_high_bank, chr_high_bank_next;
  logic signed [LAST_W-1:0] last_write_stamp, last_write_stamp_next;

  // pipeline
  logic              accept;
  logic              s1_valid, s1_move;
  logic [1:0]        s1_kind;
  logic [ADDR_W-1:0] s1_addr;
  logic [1:0]        s1_mirror;
  logic              s1_taken;
  logic              out_valid;
  logic [1:0]        out_kind;
  logic [ADDR_W-1:0] out_addr;
  logic [DATA_W-1:0] out_data;
  logic [1:0]        out_mirror;
  logic              out_taken;

  // decode
  logic [ADDR_W-1:0] a;
  logic              is_ram, is_rom;
  logic [1:0]        kind;
  logic [ADDR_W-1:0] map_addr;
  logic              loader_hit, stamp_ok, taken;
  logic signed [LAST_W:0] stamp_ext, stamp_limit;
  logic [4:0]        shifted;

  // ram
  logic              ram_we, ram_re;
  logic [12:0]       ram_off, ram_base;
  logic [RAM_AW-1:0] ram_index;
  logic [DATA_W-1:0] ram_rdata;

  // bank reduction tables, worked out at elaboration
  logic [1:0] prg_mod  [16];
  logic [2:0] chr8_mod [16];
  logic [3:0] chr4_mod [32];
  logic [1:0] prg_last;
  logic [3:0] prg_sel;
  logic [3:0] prg_pick;
  logic [4:0] chr_bank4;

  for (genvar i = 0; i < 16; i++) begin : g_mod16
    assign prg_mod[i]  = 2'(i % PRG_BANK_COUNT);
    assign chr8_mod[i] = 3'(i % CHR_BANK_COUNT);
  end
  for (genvar i = 0; i < 32; i++) begin : g_mod32
    assign chr4_mod[i] = 4'(i % (2 * CHR_BANK_COUNT));
  end
  assign prg_last = 2'(PRG_BANK_COUNT - 1);

  assign a      = req.bus_address;
  assign is_ram = (a[15:13] == 3'b011);
  assign is_rom = a[15];

  // ram index: offset into the window, folded onto smaller rams
  assign ram_off = a[12:0];
  always_comb begin
    ram_base = '0;
    for (int k = 1; k < 8; k++) begin
      if (k * RAM_BYTES < WIN_SIZE && ram_off >= 13'(k * RAM_BYTES)) begin
        ram_base = 13'(k * RAM_BYTES);
      end
    end
  end
  assign ram_index = RAM_AW'(ram_off - ram_base);

  // prg mapping
  assign prg_sel = prg_bank_reg[3:0];
  always_comb begin
    if (!a[14]) begin
      case (control_reg[3:2])
        2'd0, 2'd1: prg_pick = prg_sel & 4'hE;
        2'd2:       prg_pick = 4'd0;
        default:    prg_pick = prg_sel;
      endcase
    end else begin
      case (control_reg[3:2])
        2'd0, 2'd1: prg_pick = prg_sel | 4'h1;
        2'd2:       prg_pick = prg_sel;
        default:    prg_pick = {2'b00, prg_last};
      endcase
    end
  end

  assign chr_bank4 = a[12] ? chr_high_bank : chr_low_bank;

  // request decode
  always_comb begin
    kind     = KIND_NONE;
    map_addr = '0;
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    loader_hit = 1'b0;
    case (req.op)
      OP_CPU_WRITE: begin
        ram_we     = accept && is_ram && !prg_bank_reg[4];
        loader_hit = is_rom;
      end
      OP_CPU_READ: begin
        if (is_ram) begin
          kind   = KIND_RAM;
          ram_re = accept;
        end else if (is_rom) begin
          kind     = KIND_PRG;
          map_addr = {prg_mod[prg_pick], a[13:0]};
        end
      end
      OP_PPU_READ: begin
        kind = KIND_CHR;
        if (!control_reg[4]) begin
          map_addr = {chr8_mod[chr_low_bank[4:1]], a[12:0]};
        end else begin
          map_addr = {chr4_mod[chr_bank4], a[11:0]};
        end
      end
      default: kind = KIND_NONE;
    endcase
  end

  // ignore rule: stamp must exceed the last taken loader write stamp plus one
  assign stamp_ext   = signed'({2'b00, req.cycle_stamp});
  assign stamp_limit = signed'({last_write_stamp[LAST_W-1], last_write_stamp})
                       + (LAST_W+1)'(1);
  assign stamp_ok    = stamp_ext > stamp_limit;
  assign taken       = loader_hit && stamp_ok;
  assign shifted     = {req.write_data[0], load_shift[4:1]};

  // serial loader
  always_comb begin
    load_shift_next       = load_shift;
    load_count_next       = load_count;
    control_reg_next      = control_reg;
    prg_bank_reg_next     = prg_bank_reg;
    chr_low_bank_next     = chr_low_bank;
    chr_high_bank_next    = chr_high_bank;
    last_write_stamp_next = last_write_stamp;
    if (taken) begin
      last_write_stamp_next = signed'({1'b0, req.cycle_stamp});
      if (req.write_data[7]) begin
        load_shift_next  = LOAD_SHIFT_RESET;
        load_count_next  = '0;
        control_reg_next = control_reg | CONTROL_LOADER_SET;
      end else if (load_count == LOAD_LAST_COUNT) begin
        // fifth bit: commit to the register picked by the address
        load_shift_next = LOAD_SHIFT_RESET;
        load_count_next = '0;
        case (load_target_t'(a[14:13]))
          TGT_CONTROL:  control_reg_next   = shifted;
          TGT_CHR_LOW:  chr_low_bank_next  = shifted;
          TGT_CHR_HIGH: chr_high_bank_next = shifted;
          default:      prg_bank_reg_next  = shifted;
        endcase
      end else begin
        load_shift_next = shifted;
        load_count_next = load_count + 3'd1;
      end
    end
  end

  // handshake: ram stage feeds the output register
  assign s1_move   = s1_valid && (!out_valid || rsp.ready);
  assign req.ready = !s1_valid || s1_move;
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      load_shift       <= LOAD_SHIFT_RESET;
      load_count       <= '0;
      control_reg      <= CONTROL_RESET;
      prg_bank_reg     <= '0;
      chr_low_bank     <= '0;
      chr_high_bank    <= '0;
      last_write_stamp <= LAST_STAMP_RESET;
      s1_valid         <= 1'b0;
      out_valid        <= 1'b0;
    end else begin
      if (accept) begin
        load_shift       <= load_shift_next;
        load_count       <= load_count_next;
        control_reg      <= control_reg_next;
        prg_bank_reg     <= prg_bank_reg_next;
        chr_low_bank     <= chr_low_bank_next;
        chr_high_bank    <= chr_high_bank_next;
        last_write_stamp <= last_write_stamp_next;
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind   <= kind;
      s1_addr   <= map_addr;
      s1_mirror <= control_reg_next[1:0];
      s1_taken  <= taken;
    end
    if (s1_move) begin
      out_kind   <= s1_kind;
      out_addr   <= s1_addr;
      out_data   <= (s1_kind == KIND_RAM) ? ram_rdata : '0;
      out_mirror <= s1_mirror;
      out_taken  <= s1_taken;
    end
  end

  // work ram: read data lands with the ram stage and holds while it stalls
  mmc1_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RAM_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_index),
    .wdata (req.write_data),
    .rdata (ram_rdata)
  );

  assign rsp.valid       = out_valid;
  assign rsp.result_kind = out_kind;
  assign rsp.rom_address = out_addr;
  assign rsp.read_data   = out_data;
  assign rsp.mirroring   = out_mirror;
  assign rsp.write_taken = out_taken;

endmodule
